// ----- rtl/sm3_pkg.sv -----
// Shared constants and helpers for the SM3 hash engine.
package sm3_pkg;

   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] chain_type;

   localparam chain_type IV = {32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
                               32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f};

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      begin
         d = {x, x} << n;
         return d[63:32];
      end
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ----- rtl/sm3_round.sv -----
// One SM3 compression round and one message expansion step per cycle while step is high.
module sm3_round import sm3_pkg::*; (
   input  logic      clock,
   input  logic      load,
   input  logic      step,
   input  chain_type chain,
   input  word_type  blk [16],
   input  logic [5:0] round,
   output chain_type regs
);
   chain_type r_ff, r_in;
   word_type  w_ff [16];
   word_type  w_in [16];
   word_type  a12, ss1, ss2, ff, gg, tt1, tt2, t, wj, wj4, nw;
   logic [3:0] j;

   assign regs = r_ff;

   always_comb begin
      j   = round[3:0];
      wj  = w_ff[j];
      wj4 = w_ff[j + 4'd4];
      t   = (round < 6'd16) ? T_LOW : T_HIGH;
      a12 = rotl(r_ff[0], 5'd12);
      ss1 = rotl(a12 + r_ff[4] + rotl(t, round[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (round < 6'd16) begin
         ff = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         gg = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ff = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         gg = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = ff + r_ff[3] + ss2 + (wj ^ wj4);
      tt2 = gg + r_ff[7] + ss1 + wj;
      nw  = perm1(wj ^ w_ff[j + 4'd7] ^ rotl(w_ff[j + 4'd13], 5'd15))
            ^ rotl(w_ff[j + 4'd3], 5'd7) ^ w_ff[j + 4'd10];
      r_in = r_ff;
      w_in = w_ff;
      if (load) begin
         r_in = chain;
         w_in = blk;
      end else if (step) begin
         r_in[3] = r_ff[2];
         r_in[2] = rotl(r_ff[1], 5'd9);
         r_in[1] = r_ff[0];
         r_in[0] = tt1;
         r_in[7] = r_ff[6];
         r_in[6] = rotl(r_ff[5], 5'd19);
         r_in[5] = r_ff[4];
         r_in[4] = perm0(tt2);
         w_in[j] = nw;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      w_ff <= w_in;
   end
endmodule

// ----- rtl/sm3_hash_engine.sv -----
// SM3 hash engine top level: word intake, padding, compression control, digest output.
// SM3 hash engine. Message words arrive big-endian with a valid byte count and a
// last flag; after the last word eight digest words leave, word 0 first. A word
// that does not fill a block leaves the engine ready for the next word. A word
// that completes a 16-word block holds the engine for a load, 64 rounds of the
// shared round unit and a chain update. The last word adds padding words at one
// per cycle while no compression runs, plus one or two compressions, then 8 output
// transfers; the engine takes no input until the digest has been sent and is then
// ready for a new message.
module sm3_hash_engine import sm3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);
   localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_LOAD = 3'd2, S_ROUND = 3'd3,
                          S_FOLD = 3'd4, S_OUT = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_ff, out_in;
   logic        fin_ff, fin_in;     // padding pending or in progress
   logic [1:0]  padk_ff, padk_in;   // 0: zero fill, 1: length high, 2: length low, 3: pad word owed
   chain_type   cv_ff, cv_in;
   word_type    blk_ff [16];
   chain_type   regs;
   logic        push;
   word_type    push_word;
   logic        load, step;
   logic [2:0]  nb;
   word_type    keep, padded;
   logic [63:0] len_new;

   sm3_round u_round (
      .clock(clock), .load(load), .step(step), .chain(cv_ff), .blk(blk_ff),
      .round(round_ff), .regs(regs)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = cv_ff[out_ff];
   assign rsp_digest_last = (out_ff == 3'd7);

   always_comb begin
      nb = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
      if (!req_last_word) nb = 3'd4;
      keep = (nb == 3'd0) ? 32'd0 : (32'hffffffff << (6'd32 - {nb, 3'b000}));
      padded = (req_message_word & keep) | ({24'd0, PAD_BYTE} << (5'd24 - {nb[1:0], 3'b000}));
      len_new = len_ff + {58'd0, nb, 3'b000};
   end

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; len_in = len_ff; round_in = round_ff;
      out_in = out_ff; fin_in = fin_ff; padk_in = padk_ff; cv_in = cv_ff;
      push = 1'b0; push_word = 32'd0; load = 1'b0; step = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               len_in = len_new;
               push = 1'b1;
               if (req_last_word && nb != 3'd4) push_word = padded;
               else push_word = req_message_word;
               if (req_last_word) begin
                  fin_in  = 1'b1;
                  padk_in = (nb == 3'd4) ? 2'd3 : 2'd0; // 3: pad word still owed
               end
            end
         end
         S_PAD: begin
            push = 1'b1;
            unique case (padk_ff)
               2'd3: begin push_word = {PAD_BYTE, 24'd0}; padk_in = 2'd0; end
               2'd0: push_word = 32'd0;
               2'd1: begin push_word = len_ff[63:32]; padk_in = 2'd2; end
               default: push_word = len_ff[31:0];
            endcase
         end
         S_LOAD: begin
            load = 1'b1; round_in = 6'd0; state_in = S_ROUND;
         end
         S_ROUND: begin
            step = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = S_FOLD;
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) cv_in[i] = cv_ff[i] ^ regs[i];
            if (fin_ff && padk_ff == 2'd2) begin
               state_in = S_OUT; out_in = 3'd0;
            end else if (fin_ff) state_in = S_PAD;
            else state_in = S_IDLE;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  state_in = S_IDLE; cv_in = IV; len_in = 64'd0; fin_in = 1'b0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (push) begin
         fill_in = fill_ff + 4'd1;
         // after a push, go to load when the block is full, or to padding after the last word
         if (state_ff == S_IDLE) begin
            if (fill_ff == 4'd15) state_in = S_LOAD;
            else if (req_last_word) state_in = S_PAD;
         end else begin
            if (fill_ff == 4'd15) state_in = S_LOAD;
         end
         // zero fill: length fits only if at most 14 words held, so switch to it at 14
         if (padk_in == 2'd0 && fill_in == 4'd14) padk_in = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) blk_ff[fill_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= 4'd0; len_ff <= 64'd0; round_ff <= 6'd0;
         out_ff <= 3'd0; fin_ff <= 1'b0; padk_ff <= 2'd0; cv_ff <= IV;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; len_ff <= len_in; round_ff <= round_in;
         out_ff <= out_in; fin_ff <= fin_in; padk_ff <= padk_in; cv_ff <= cv_in;
      end
   end
endmodule
